[rtl/core/espa_pkg.sv]
// shared types, constants and the erf sample table for the screened potential accumulator
`timescale 1ns / 1ps
package espa_pkg;

    localparam int ERF_TABLE_POINTS = 256;
    localparam int ERF_IDX_W        = $clog2(ERF_TABLE_POINTS);
    localparam int SQ_STEPS         = 4;
    localparam int SQRT_STEPS       = 33;
    localparam int NUM_W            = 96;
    localparam int DIV_STEPS        = NUM_W;
    localparam int CNT_W            = $clog2(DIV_STEPS + 1);
    localparam logic [63:0] TWO_OVER_SQRTPI_Q52 = 64'h0120_DD75_0429_B6D;

    typedef struct packed {
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
        logic signed [31:0] source_x;
        logic signed [31:0] source_y;
        logic signed [31:0] source_z;
        logic signed [31:0] charge;
        logic signed [31:0] weight;
        logic               last_pair;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0] potential;
        logic               saturated;
    } t_out_item;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SQ,
        OP_SQRT,
        OP_XMUL,
        OP_INTERP,
        OP_EFIN,
        OP_PLO,
        OP_PHI,
        OP_DIV,
        OP_ACC,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic r2_zero;
        logic out_busy;
        logic last;
    } t_status;

    typedef logic [ERF_TABLE_POINTS-1:0][31:0] t_erf_tab;

    // floor(a*b / 2^s)
    function automatic logic [63:0] mul_shift(input logic [63:0] a, input logic [63:0] b,
                                              input int s);
        logic [127:0] p;
        begin
            p = {64'd0, a} * {64'd0, b};
            mul_shift = 64'(p >> s);
        end
    endfunction

    // floor(a / d) by shift and subtract, d nonzero
    function automatic logic [63:0] div_u64(input logic [63:0] a, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        int k;
        begin
            rem = '0;
            q   = '0;
            for (k = 63; k >= 0; k--) begin
                rem = {rem[63:0], a[k]};
                if (rem >= {1'b0, d}) begin
                    rem  = rem - {1'b0, d};
                    q[k] = 1'b1;
                end
            end
            div_u64 = q;
        end
    endfunction

    // erf of a Q32 argument below 4, by integer series, result in Q32
    function automatic logic [31:0] erf_sample(input logic [63:0] x);
        logic [63:0] y, s, t, z, e, ti, p, v, dv;
        int n;
        begin
            y = mul_shift(x, x, 32);
            s = 64'd0;
            t = x;
            for (n = 0; n < 256; n++) begin
                if (t != 64'd0) begin
                    s  = s + t;
                    dv = 64'(2 * n + 3);
                    t  = div_u64(mul_shift(t, y << 1, 32), dv);
                end
            end
            z  = y << 25;
            e  = 64'd1 << 62;
            ti = 64'd1 << 62;
            for (n = 1; n < 25; n++) begin
                dv = 64'(n);
                ti = div_u64(mul_shift(ti, z, 62), dv);
                if ((n % 2) == 1) begin
                    e = e - ti;
                end else begin
                    e = e + ti;
                end
            end
            for (n = 0; n < 5; n++) begin
                e = mul_shift(e, e, 62);
            end
            p = mul_shift(s, e, 62);
            v = mul_shift(p, TWO_OVER_SQRTPI_Q52, 52);
            erf_sample = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
    endfunction

    function automatic t_erf_tab build_erf_table();
        t_erf_tab tab;
        logic [63:0] x;
        int i;
        begin
            for (i = 0; i < ERF_TABLE_POINTS; i++) begin
                x = (64'(i) << 34) / 64'(ERF_TABLE_POINTS);
                tab[i] = erf_sample(x);
            end
            build_erf_table = tab;
        end
    endfunction

    localparam t_erf_tab ERF_TABLE = build_erf_table();

endpackage

[rtl/core/erf_screened_potential_accumulator_core.sv]
// top level of the screened coulomb potential accumulator
`timescale 1ns / 1ps
// usage
//   input channel: one item per source-target pair, accepted when i_in_valid and
//   o_in_ready are both high; last_pair closes the current target
//   output channel: one item per target, the Q32.32 potential sum and a
//   saturation flag, taken when o_out_valid and i_out_ready are both high
//   config: i_cfg_we writes inv_eta (unsigned Q16.16) at the clock edge; write
//   only while the block is idle
// steps
//   a pair runs from accept to ready again through square, check, square root,
//   erf and product, divide, accumulate and finish; the one-bit-per-cycle
//   divider by r is the longest step
//   a zero-distance pair goes from the check straight to the finish step
//   the result of a last pair is loaded into the output register by the finish
//   step
// reset
//   synchronous, active low: clears the sum, the clip flag, the output valid and
//   sets inv_eta to 1.0
// stall
//   the output register holds one result; a new target's last pair waits in
//   its finish step until that result is taken, earlier pairs run on
module erf_screened_potential_accumulator_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  espa_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output espa_pkg::t_out_item o_out_item,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);
    import espa_pkg::*;

    t_cmd    cmd;
    t_status status;

    // sequencer: counts steps, one op per cycle; none at the check, in a finish with no emit, or idle with no input
    espa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // datapath: distance, sqrt, erf interpolation, divide, saturating sum
    espa_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .o_status    (status)
    );
endmodule

[rtl/core/espa_ctrl.sv]
// sequencer for one source-target pair
`timescale 1ns / 1ps
module espa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  espa_pkg::t_status i_status,
    output espa_pkg::t_cmd    o_cmd
);
    import espa_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SQ, S_CHK, S_SQRT, S_XMUL, S_INTERP, S_EFIN,
        S_PLO, S_PHI, S_DIV, S_ACC, S_END
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_cnt;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd.op = OP_NONE;
        case (r_state)
            S_IDLE:   o_cmd.op = i_in_valid ? OP_LOAD : OP_NONE;
            S_SQ:     o_cmd.op = OP_SQ;
            S_SQRT:   o_cmd.op = OP_SQRT;
            S_XMUL:   o_cmd.op = OP_XMUL;
            S_INTERP: o_cmd.op = OP_INTERP;
            S_EFIN:   o_cmd.op = OP_EFIN;
            S_PLO:    o_cmd.op = OP_PLO;
            S_PHI:    o_cmd.op = OP_PHI;
            S_DIV:    o_cmd.op = OP_DIV;
            S_ACC:    o_cmd.op = OP_ACC;
            S_END:    o_cmd.op = (i_status.last && !i_status.out_busy) ? OP_EMIT : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= S_SQ;
                        r_cnt   <= '0;
                    end
                end
                S_SQ: begin
                    if (r_cnt == CNT_W'(SQ_STEPS - 1)) begin
                        r_state <= S_CHK;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_CHK: begin
                    // zero distance adds nothing
                    r_state <= i_status.r2_zero ? S_END : S_SQRT;
                    r_cnt   <= '0;
                end
                S_SQRT: begin
                    if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                        r_state <= S_XMUL;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_XMUL:   r_state <= S_INTERP;
                S_INTERP: r_state <= S_EFIN;
                S_EFIN:   r_state <= S_PLO;
                S_PLO:    r_state <= S_PHI;
                S_PHI: begin
                    r_state <= S_DIV;
                    r_cnt   <= '0;
                end
                S_DIV: begin
                    if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_ACC;
                    end
                    r_cnt <= r_cnt + 1'b1;
                end
                S_ACC: r_state <= S_END;
                S_END: begin
                    if (!i_status.last || !i_status.out_busy) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/core/espa_datapath.sv]
// arithmetic, accumulator, config register and output register
`timescale 1ns / 1ps
module espa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  espa_pkg::t_cmd     i_cmd,
    input  espa_pkg::t_in_item i_in_item,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output espa_pkg::t_out_item o_out_item,
    output espa_pkg::t_status  o_status
);
    import espa_pkg::*;

    logic [31:0]        r_inv_eta;
    logic [32:0]        r_d0, r_d1, r_d2;
    logic signed [63:0] r_cw;
    logic               r_last;
    logic [62:0]        r_mag;
    logic               r_neg;
    logic [65:0]        r_sq, r_r2;
    logic [35:0]        r_rem;
    logic [32:0]        r_root;
    logic [64:0]        r_x;
    logic [31:0]        r_a;
    logic [64:0]        r_iprod;
    logic [1:0]         r_ecase;
    logic [32:0]        r_e;
    logic [63:0]        r_p;
    logic [NUM_W-1:0]   r_num;
    logic [49:0]        r_drem;
    logic [63:0]        r_q;
    logic               r_ovf;
    logic signed [63:0] r_sum;
    logic               r_clip;
    logic               r_out_valid;
    t_out_item          r_out_item;

    localparam logic [1:0] E_ZERO = 2'd0;
    localparam logic [1:0] E_ONE  = 2'd1;
    localparam logic [1:0] E_TAB  = 2'd2;

    // pair differences
    logic signed [32:0] dx, dy, dz;
    logic [32:0]        ax, ay, az;
    logic signed [63:0] cw_neg;
    always_comb begin
        dx = {i_in_item.target_x[31], i_in_item.target_x}
           - {i_in_item.source_x[31], i_in_item.source_x};
        dy = {i_in_item.target_y[31], i_in_item.target_y}
           - {i_in_item.source_y[31], i_in_item.source_y};
        dz = {i_in_item.target_z[31], i_in_item.target_z}
           - {i_in_item.source_z[31], i_in_item.source_z};
        ax = dx[32] ? 33'(-dx) : 33'(dx);
        ay = dy[32] ? 33'(-dy) : 33'(dy);
        az = dz[32] ? 33'(-dz) : 33'(dz);
        cw_neg = -r_cw;
    end

    // square root step
    logic [35:0] sq_rem, sq_trial;
    always_comb begin
        sq_rem   = {r_rem[33:0], r_r2[65:64]};
        sq_trial = {1'b0, r_root, 2'b01};
    end

    // erf lookup
    logic [ERF_IDX_W-1:0] idx;
    logic [31:0]          frac, ta;
    logic [32:0]          tb, tdiff;
    logic                 far;
    always_comb begin
        far   = (r_x[64:34] != '0);
        idx   = r_x[33 -: ERF_IDX_W];
        frac  = {r_x[33-ERF_IDX_W:0], {(ERF_IDX_W-2){1'b0}}};
        ta    = ERF_TABLE[idx];
        tb    = (idx == ERF_IDX_W'(ERF_TABLE_POINTS - 1)) ? 33'h1_0000_0000
                                                         : {1'b0, ERF_TABLE[idx + 1'b1]};
        tdiff = (tb >= {1'b0, ta}) ? (tb - {1'b0, ta}) : 33'd0;
    end

    // divide step
    logic [49:0] dv_rem, dv_d;
    logic        dv_bit;
    always_comb begin
        dv_d   = {1'b0, r_root, 16'd0};
        dv_rem = {r_drem[48:0], r_num[NUM_W-1]};
        dv_bit = (dv_rem >= dv_d);
        if (dv_bit) begin
            dv_rem = dv_rem - dv_d;
        end
    end

    // saturating accumulate
    logic [63:0]        qs;
    logic               qclip;
    logic signed [64:0] s65;
    logic               sovf;
    always_comb begin
        qclip = r_ovf || r_q[63];
        qs    = qclip ? 64'h7FFF_FFFF_FFFF_FFFF : r_q;
        s65   = r_neg ? ({r_sum[63], r_sum} - {1'b0, qs})
                      : ({r_sum[63], r_sum} + {1'b0, qs});
        sovf  = (s65[64] != s65[63]);
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD: begin
                r_d0   <= ax;
                r_d1   <= ay;
                r_d2   <= az;
                r_cw   <= i_in_item.charge * i_in_item.weight;
                r_last <= i_in_item.last_pair;
                r_sq   <= '0;
                r_r2   <= '0;
                r_rem  <= '0;
                r_root <= '0;
            end
            OP_SQ: begin
                r_r2  <= r_r2 + r_sq;
                r_sq  <= r_d0 * r_d0;
                r_d0  <= r_d1;
                r_d1  <= r_d2;
                r_d2  <= r_d0;
                r_neg <= r_cw[63];
                r_mag <= r_cw[63] ? cw_neg[62:0] : r_cw[62:0];
            end
            OP_SQRT: begin
                r_r2 <= {r_r2[63:0], 2'b00};
                if (sq_rem >= sq_trial) begin
                    r_rem  <= sq_rem - sq_trial;
                    r_root <= {r_root[31:0], 1'b1};
                end else begin
                    r_rem  <= sq_rem;
                    r_root <= {r_root[31:0], 1'b0};
                end
            end
            OP_XMUL: r_x <= r_root * r_inv_eta;
            OP_INTERP: begin
                r_a     <= ta;
                r_iprod <= tdiff * frac;
                if (r_inv_eta == '0) begin
                    r_ecase <= E_ZERO;
                end else if (far) begin
                    r_ecase <= E_ONE;
                end else begin
                    r_ecase <= E_TAB;
                end
            end
            OP_EFIN: begin
                case (r_ecase)
                    E_ZERO:  r_e <= '0;
                    E_ONE:   r_e <= 33'h1_0000_0000;
                    default: r_e <= {1'b0, r_a} + r_iprod[64:32];
                endcase
            end
            OP_PLO: r_p <= r_mag[31:0] * r_e[31:0];
            OP_PHI: begin
                if (r_e[32]) begin
                    r_num <= {1'b0, r_mag, 32'd0};
                end else begin
                    r_num <= {63'(r_mag[62:32]) * 63'(r_e[31:0]), 32'd0} + NUM_W'(r_p);
                end
                r_drem <= '0;
                r_q    <= '0;
                r_ovf  <= 1'b0;
            end
            OP_DIV: begin
                r_num  <= {r_num[NUM_W-2:0], 1'b0};
                r_drem <= dv_rem;
                r_q    <= {r_q[62:0], dv_bit};
                r_ovf  <= r_ovf | r_q[63];
            end
            OP_EMIT: begin
                r_out_item.potential <= r_sum;
                r_out_item.saturated <= r_clip;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_eta   <= 32'd65536;
            r_sum       <= '0;
            r_clip      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_inv_eta <= i_cfg_wdata;
            end
            if (i_cmd.op == OP_ACC) begin
                if (sovf) begin
                    r_sum  <= s65[64] ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
                    r_clip <= 1'b1;
                end else begin
                    r_sum  <= s65[63:0];
                    r_clip <= r_clip | qclip;
                end
            end
            if (i_cmd.op == OP_EMIT) begin
                r_sum       <= '0;
                r_clip      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_item        = r_out_item;
    assign o_status.r2_zero  = (r_r2 == '0);
    assign o_status.out_busy = r_out_valid;
    assign o_status.last     = r_last;
endmodule

[rtl/core/espa_checker.sv]
// port-level checks for the accumulator, bound to the top level
`timescale 1ns / 1ps
module espa_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input espa_pkg::t_out_item o_out_item
);
    import espa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output item dropped or changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after an accept");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("reset did not clear the handshake");
endmodule

bind erf_screened_potential_accumulator_core espa_checker u_espa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
